/* hw/rtl/trce_pkg.sv */
// Shared types, limits and helpers for the table row/column editor.
// Depends on nothing; trce_ctrl, the top level and the checker import it.
`default_nettype none

package trce_pkg;

   localparam int MAX_ROWS  = 64;
   localparam int MAX_COLS  = 64;
   localparam int CELL_BITS = 32;

   // usable limits, capped so a count fits its 7-bit field
   localparam int ROW_LIM = (MAX_ROWS < 127) ? MAX_ROWS : 127;
   localparam int COL_LIM = (MAX_COLS < 127) ? MAX_COLS : 127;

   localparam int CMD_W  = 4;
   localparam int CNT_W  = 7;
   localparam int WORD_W = 32;
   localparam int STAT_W = 2;

   localparam int ROW_IW = $clog2(ROW_LIM);
   localparam int COL_IW = $clog2(COL_LIM);
   localparam int CELLS  = ROW_LIM * COL_LIM;
   localparam int ADDR_W = $clog2(CELLS);

   localparam logic [CNT_W-1:0] ROW_LIM_C = CNT_W'(ROW_LIM);
   localparam logic [CNT_W-1:0] COL_LIM_C = CNT_W'(COL_LIM);

   typedef enum logic [CMD_W-1:0] {
      CMD_SET_SIZE  = 4'd0,
      CMD_WRITE     = 4'd1,
      CMD_READ      = 4'd2,
      CMD_SWAP_ROWS = 4'd3,
      CMD_SWAP_COLS = 4'd4,
      CMD_DEL_ROW   = 4'd5,
      CMD_DEL_COL   = 4'd6,
      CMD_INS_ROW   = 4'd7,
      CMD_INS_COL   = 4'd8
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic                 we;
      logic [ADDR_W-1:0]    waddr;
      logic [CELL_BITS-1:0] wdata;
      logic [ADDR_W-1:0]    raddr;
   } ram_req_type;

   // row-major cell address; indices are always below their limits here
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [CNT_W-1:0] row,
                                                    input logic [CNT_W-1:0] col);
      return ADDR_W'(ADDR_W'(row[ROW_IW-1:0]) * ADDR_W'(COL_LIM)
                     + ADDR_W'(col[COL_IW-1:0]));
   endfunction

   // sign-extend (or trim) a stored cell to the result word
   function automatic logic [WORD_W-1:0] cell_to_word(input logic [CELL_BITS-1:0] raw);
      return WORD_W'($signed(raw));
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/trce_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module trce_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

/* hw/rtl/trce_ctrl.sv */
// Command sequencer: decode, bounds checks, counts, and the read-modify-write
// walks over the cell RAM. Depends on trce_pkg.
`default_nettype none

module trce_ctrl import trce_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire logic [CMD_W-1:0]         req_cmd,
   input  wire logic [CNT_W-1:0]         req_first,
   input  wire logic [CNT_W-1:0]         req_second,
   input  wire logic signed [WORD_W-1:0] req_value,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic signed [WORD_W-1:0] rsp_read_value,
   output      logic [STAT_W-1:0]        rsp_status,
   output      logic [CNT_W-1:0]         rsp_rows_now,
   output      logic [CNT_W-1:0]         rsp_cols_now,
   output      ram_req_type              ram_req,
   input  wire logic [CELL_BITS-1:0]     ram_rdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_MOVE,
      ST_SWAP_RA,
      ST_SWAP_RB,
      ST_SWAP_WA,
      ST_SWAP_WB,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [CNT_W-1:0]     first_ff, first_in;
   logic [CNT_W-1:0]     second_ff, second_in;
   logic [WORD_W-1:0]    value_ff, value_in;
   logic [CNT_W-1:0]     rows_ff, rows_in;
   logic [CNT_W-1:0]     cols_ff, cols_in;
   logic [CNT_W-1:0]     rows_next_ff, rows_next_in;
   logic [CNT_W-1:0]     cols_next_ff, cols_next_in;
   status_type           status_ff, status_in;
   logic [WORD_W-1:0]    rd_ff, rd_in;
   logic [CNT_W-1:0]     line_ff, line_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [CELL_BITS-1:0] tmp_ff, tmp_in;
   logic                 pend_ff, pend_in;
   logic [ADDR_W-1:0]    pend_addr_ff, pend_addr_in;
   logic                 pend_zero_ff, pend_zero_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_value_ff, rsp_value_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]     rsp_rows_ff, rsp_rows_in;
   logic [CNT_W-1:0]     rsp_cols_ff, rsp_cols_in;

   status_type           dec_status;
   logic [CNT_W-1:0]     line_start, pos_start;
   logic                 pos_last, line_last, walk_empty;
   logic                 line_down, pos_down, step_zero;
   logic [CNT_W-1:0]     src_row, src_col;
   logic [ADDR_W-1:0]    dst_addr, src_addr, swap_a, swap_b;

   // bounds checks against the counts held before the command
   always_comb begin
      case (cmd_ff)
         CMD_SET_SIZE:
            dec_status = (first_ff > ROW_LIM_C || second_ff > COL_LIM_C) ?
                         STATUS_RANGE : STATUS_OK;
         CMD_WRITE, CMD_READ:
            dec_status = (first_ff >= rows_ff || second_ff >= cols_ff) ?
                         STATUS_RANGE : STATUS_OK;
         CMD_SWAP_ROWS:
            dec_status = (first_ff >= rows_ff || second_ff >= rows_ff) ?
                         STATUS_RANGE : STATUS_OK;
         CMD_SWAP_COLS:
            dec_status = (first_ff >= cols_ff || second_ff >= cols_ff) ?
                         STATUS_RANGE : STATUS_OK;
         CMD_DEL_ROW: dec_status = (first_ff >= rows_ff) ? STATUS_RANGE : STATUS_OK;
         CMD_DEL_COL: dec_status = (first_ff >= cols_ff) ? STATUS_RANGE : STATUS_OK;
         CMD_INS_ROW:
            dec_status = (first_ff > rows_ff)    ? STATUS_RANGE :
                         (rows_ff >= ROW_LIM_C)  ? STATUS_FULL  : STATUS_OK;
         CMD_INS_COL:
            dec_status = (first_ff > cols_ff)    ? STATUS_RANGE :
                         (cols_ff >= COL_LIM_C)  ? STATUS_FULL  : STATUS_OK;
         default: dec_status = STATUS_RANGE;
      endcase
   end

   // walk shape: line is the outer counter, pos the inner one; dst is (line, pos)
   always_comb begin
      line_start = '0;
      pos_start  = '0;
      pos_last   = 1'b1;
      line_last  = 1'b1;
      walk_empty = 1'b1;
      line_down  = 1'b0;
      pos_down   = 1'b0;
      step_zero  = 1'b0;
      src_row    = line_ff;
      src_col    = pos_ff;
      swap_a     = cell_addr(first_ff, pos_ff);
      swap_b     = cell_addr(second_ff, pos_ff);
      case (cmd_ff)
         CMD_DEL_ROW: begin
            line_start = first_ff;
            pos_last   = (pos_ff == cols_ff - CNT_W'(1));
            line_last  = ((CNT_W+1)'(line_ff) + (CNT_W+1)'(2)) >= (CNT_W+1)'(rows_ff);
            walk_empty = ((CNT_W+1)'(first_ff) + (CNT_W+1)'(1)) >= (CNT_W+1)'(rows_ff)
                         || cols_ff == '0;
            src_row    = line_ff + CNT_W'(1);
         end
         CMD_INS_ROW: begin
            line_start = rows_ff;
            line_down  = 1'b1;
            pos_last   = (pos_ff == cols_ff - CNT_W'(1));
            line_last  = (line_ff == first_ff);
            walk_empty = (cols_ff == '0);
            step_zero  = (line_ff == first_ff);
            src_row    = line_ff - CNT_W'(1);
         end
         CMD_DEL_COL: begin
            pos_start  = first_ff;
            pos_last   = ((CNT_W+1)'(pos_ff) + (CNT_W+1)'(2)) >= (CNT_W+1)'(cols_ff);
            line_last  = (line_ff == rows_ff - CNT_W'(1));
            walk_empty = (rows_ff == '0)
                         || ((CNT_W+1)'(first_ff) + (CNT_W+1)'(1)) >= (CNT_W+1)'(cols_ff);
            src_col    = pos_ff + CNT_W'(1);
         end
         CMD_INS_COL: begin
            pos_start  = cols_ff;
            pos_down   = 1'b1;
            pos_last   = (pos_ff == first_ff);
            line_last  = (line_ff == rows_ff - CNT_W'(1));
            walk_empty = (rows_ff == '0);
            step_zero  = (pos_ff == first_ff);
            src_col    = pos_ff - CNT_W'(1);
         end
         CMD_SWAP_ROWS: begin
            pos_last   = (pos_ff == cols_ff - CNT_W'(1));
            walk_empty = (cols_ff == '0);
         end
         CMD_SWAP_COLS: begin
            pos_last   = (pos_ff == rows_ff - CNT_W'(1));
            walk_empty = (rows_ff == '0);
            swap_a     = cell_addr(pos_ff, first_ff);
            swap_b     = cell_addr(pos_ff, second_ff);
         end
         default: begin
            walk_empty = 1'b1;
         end
      endcase
   end

   assign dst_addr = cell_addr(line_ff, pos_ff);
   assign src_addr = cell_addr(src_row, src_col);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      value_in      = value_ff;
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      rows_next_in  = rows_next_ff;
      cols_next_in  = cols_next_ff;
      status_in     = status_ff;
      rd_in         = rd_ff;
      line_in       = line_ff;
      pos_in        = pos_ff;
      tmp_in        = tmp_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_zero_in  = pend_zero_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rows_in   = rsp_rows_ff;
      rsp_cols_in   = rsp_cols_ff;

      // the write port retires the move issued in the previous cycle
      ram_req.we    = pend_ff;
      ram_req.waddr = pend_addr_ff;
      ram_req.wdata = pend_zero_ff ? '0 : ram_rdata;
      ram_req.raddr = dst_addr;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = cmd_type'(req_cmd);
               first_in  = req_first;
               second_in = req_second;
               value_in  = req_value;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            status_in    = dec_status;
            rd_in        = '0;
            rows_next_in = rows_ff;
            cols_next_in = cols_ff;
            line_in      = line_start;
            pos_in       = pos_start;
            state_in     = ST_FINISH;
            if (dec_status == STATUS_OK) begin
               case (cmd_ff)
                  CMD_SET_SIZE: begin
                     rows_next_in = first_ff;
                     cols_next_in = second_ff;
                  end
                  CMD_WRITE: begin
                     ram_req.we    = 1'b1;
                     ram_req.waddr = cell_addr(first_ff, second_ff);
                     ram_req.wdata = CELL_BITS'(value_ff);
                  end
                  CMD_READ: begin
                     ram_req.raddr = cell_addr(first_ff, second_ff);
                     state_in      = ST_READ;
                  end
                  CMD_SWAP_ROWS, CMD_SWAP_COLS: begin
                     if (!walk_empty) begin
                        state_in = ST_SWAP_RA;
                     end
                  end
                  CMD_DEL_ROW, CMD_INS_ROW, CMD_DEL_COL, CMD_INS_COL: begin
                     if (cmd_ff == CMD_DEL_ROW) rows_next_in = rows_ff - CNT_W'(1);
                     if (cmd_ff == CMD_INS_ROW) rows_next_in = rows_ff + CNT_W'(1);
                     if (cmd_ff == CMD_DEL_COL) cols_next_in = cols_ff - CNT_W'(1);
                     if (cmd_ff == CMD_INS_COL) cols_next_in = cols_ff + CNT_W'(1);
                     if (!walk_empty) begin
                        state_in = ST_MOVE;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_in    = cell_to_word(ram_rdata);
            state_in = ST_FINISH;
         end
         ST_MOVE: begin
            // a zero step needs no source; read the target instead
            ram_req.raddr = step_zero ? dst_addr : src_addr;
            pend_in       = 1'b1;
            pend_addr_in  = dst_addr;
            pend_zero_in  = step_zero;
            if (pos_last) begin
               pos_in  = pos_start;
               line_in = line_down ? line_ff - CNT_W'(1) : line_ff + CNT_W'(1);
               if (line_last) begin
                  state_in = ST_FINISH;
               end
            end else begin
               pos_in = pos_down ? pos_ff - CNT_W'(1) : pos_ff + CNT_W'(1);
            end
         end
         ST_SWAP_RA: begin
            ram_req.raddr = swap_a;
            state_in      = ST_SWAP_RB;
         end
         ST_SWAP_RB: begin
            ram_req.raddr = swap_b;
            tmp_in        = ram_rdata;
            state_in      = ST_SWAP_WA;
         end
         ST_SWAP_WA: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = swap_a;
            ram_req.wdata = ram_rdata;
            state_in      = ST_SWAP_WB;
         end
         ST_SWAP_WB: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = swap_b;
            ram_req.wdata = tmp_ff;
            if (pos_last) begin
               state_in = ST_FINISH;
            end else begin
               pos_in   = pos_ff + CNT_W'(1);
               state_in = ST_SWAP_RA;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_ff;
               rsp_status_in = status_ff;
               rsp_rows_in   = rows_next_ff;
               rsp_cols_in   = cols_next_ff;
               rows_in       = rows_next_ff;
               cols_in       = cols_next_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= '0;
         cols_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      first_ff      <= first_in;
      second_ff     <= second_in;
      value_ff      <= value_in;
      rows_next_ff  <= rows_next_in;
      cols_next_ff  <= cols_next_in;
      status_ff     <= status_in;
      rd_ff         <= rd_in;
      line_ff       <= line_in;
      pos_ff        <= pos_in;
      tmp_ff        <= tmp_in;
      pend_addr_ff  <= pend_addr_in;
      pend_zero_ff  <= pend_zero_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rows_ff   <= rsp_rows_in;
      rsp_cols_ff   <= rsp_cols_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_rows_now   = rsp_rows_ff;
   assign rsp_cols_now   = rsp_cols_ff;

endmodule

`default_nettype wire

/* hw/rtl/table_row_column_editor_core.sv */
// Top level of the table row/column editor: sequencer plus cell RAM.
// Depends on trce_pkg, trce_ctrl and trce_ram.
//
//   channel  direction  handshake              word
//   req_     in         req_valid / req_ready  cmd, first, second, value
//   rsp_     out        rsp_valid / rsp_ready  read_value, status, rows_now, cols_now
//
// One command at a time. Set size, write and refused commands go from decode
// straight to the finish state; a read passes the read state on the way. A swap
// takes each exchanged cell pair through the read-A, read-B, write-A and write-B
// states; delete and insert move one cell per cycle through the RAM (read, then
// write back the next cycle), so an insert at row 0 walks every cell of the table.
// Reset clears the counts and the handshake state; cells are not cleared.
// A result waiting on rsp_ready holds in the output register; the next
// command is taken only once that result has been loaded.
`default_nettype none

module table_row_column_editor_core import trce_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire logic [CMD_W-1:0]         req_cmd,
   input  wire logic [CNT_W-1:0]         req_first,
   input  wire logic [CNT_W-1:0]         req_second,
   input  wire logic signed [WORD_W-1:0] req_value,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic signed [WORD_W-1:0] rsp_read_value,
   output      logic [STAT_W-1:0]        rsp_status,
   output      logic [CNT_W-1:0]         rsp_rows_now,
   output      logic [CNT_W-1:0]         rsp_cols_now
);

   ram_req_type          ram_req;
   logic [CELL_BITS-1:0] ram_rdata;

   // decode, check and sequence the cell walks
   trce_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_first      (req_first),
      .req_second     (req_second),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_rows_now   (rsp_rows_now),
      .rsp_cols_now   (rsp_cols_now),
      .ram_req        (ram_req),
      .ram_rdata      (ram_rdata)
   );

   // cell storage, row-major, one write and one registered read per cycle
   trce_ram #(
      .DEPTH (CELLS),
      .WIDTH (CELL_BITS)
   ) u_cells (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire

/* hw/rtl/trce_checker.sv */
// Port-level checks for the table row/column editor, bound to the top level.
// Depends on trce_pkg and table_row_column_editor_core.
`default_nettype none

module trce_checker import trce_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic signed [WORD_W-1:0] rsp_read_value,
   input wire logic [STAT_W-1:0]        rsp_status,
   input wire logic [CNT_W-1:0]         rsp_rows_now,
   input wire logic [CNT_W-1:0]         rsp_cols_now
);

   // no result word right out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word shown after reset");

   // one command at a time: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while a command is in flight");

   // a refused command reports no data
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_read_value == '0)
      else $error("read data on a refused command");

   // counts never exceed the limits
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rows_now <= ROW_LIM_C && rsp_cols_now <= COL_LIM_C)
      else $error("count beyond limit");

   // stalled result holds its valid, status and counts
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_rows_now) && $stable(rsp_cols_now))
      else $error("stalled result word changed");

endmodule

bind table_row_column_editor_core trce_checker u_trce_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_value (rsp_read_value),
   .rsp_status     (rsp_status),
   .rsp_rows_now   (rsp_rows_now),
   .rsp_cols_now   (rsp_cols_now)
);

`default_nettype wire
